>>> hdl/prcb_pkg.sv
// ----------------------------------------------------------------------------
// prcb_pkg
// Shared types and constants for the pre-roll capture buffer.
// ----------------------------------------------------------------------------
package prcb_pkg;

    // Stream and config port widths
    localparam int IN_W    = 40;
    localparam int OUT_W   = 80;
    localparam int CFG_AW  = 2;
    localparam int CFG_DW  = 18;

    // Field widths
    localparam int MODE_W  = 3;
    localparam int SMP_W   = 16;
    localparam int RIDX_W  = 14;
    localparam int CNT_W   = 15;
    localparam int RING_W  = 13;
    localparam int RATE_W  = 18;
    localparam int BYTE_W  = 16;
    localparam int DUR_W   = 24;
    localparam int DVD_W   = 26;

    localparam int MS_PER_S = 1000;

    // Register reset values
    localparam logic [CNT_W-1:0]  REC_CAP_RST  = 15'd16384;
    localparam logic [RING_W-1:0] RING_CAP_RST = 13'd4096;
    localparam logic [RATE_W-1:0] RATE_RST     = 18'd16000;

    typedef enum logic [CFG_AW-1:0] {
        CFG_REC_CAP  = 2'd0,
        CFG_RING_CAP = 2'd1,
        CFG_RATE     = 2'd2
    } cfg_idx_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH  = 3'd0,
        MODE_START = 3'd1,
        MODE_STOP  = 3'd2,
        MODE_RESET = 3'd3,
        MODE_READ  = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        BS_IDLE      = 2'd0,
        BS_RECORDING = 2'd1,
        BS_READY     = 2'd2
    } bstate_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_EXEC,
        CS_COPY_RD,
        CS_COPY_WR,
        CS_DIV_START,
        CS_DIV,
        CS_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic copy_rd;
        logic copy_wr;
        logic div_start;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  start_ok;
        logic  copy_none;
        logic  copy_last;
        logic  div_busy;
        logic  out_free;
    } status_t;

endpackage

>>> hdl/prcb_div.sv
// ----------------------------------------------------------------------------
// prcb_div
// Restoring unsigned divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module prcb_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [prcb_pkg::DVD_W-1:0]  dividend,
    input  logic [prcb_pkg::RATE_W-1:0] divisor,
    output logic                        busy,
    output logic [prcb_pkg::DVD_W-1:0]  quotient
);
    import prcb_pkg::*;

    localparam int STEPS = DVD_W / 2;
    localparam int SC_W  = $clog2(STEPS + 1);

    logic [DVD_W-1:0]  dvd_reg, quo_reg;
    logic [RATE_W-1:0] rem_reg, dsr_reg;
    logic [SC_W-1:0]   step_reg;
    logic              busy_reg;

    logic [RATE_W:0]   t1, t2;
    logic              ge1, ge2;
    logic [RATE_W-1:0] r1, r2;

    always_comb begin
        t1  = {rem_reg, dvd_reg[DVD_W-1]};
        ge1 = t1 >= {1'b0, dsr_reg};
        r1  = ge1 ? RATE_W'(t1 - {1'b0, dsr_reg}) : t1[RATE_W-1:0];
        t2  = {r1, dvd_reg[DVD_W-2]};
        ge2 = t2 >= {1'b0, dsr_reg};
        r2  = ge2 ? RATE_W'(t2 - {1'b0, dsr_reg}) : t2[RATE_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            step_reg <= SC_W'(STEPS);
        end else if (busy_reg) begin
            step_reg <= step_reg - 1'b1;
            if (step_reg == SC_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[DVD_W-3:0], 2'b00};
            rem_reg <= r2;
            quo_reg <= {quo_reg[DVD_W-3:0], ge1, ge2};
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

>>> hdl/prcb_datapath.sv
// ----------------------------------------------------------------------------
// prcb_datapath
// Config registers, record and pre-roll stores, counters and result register.
// ----------------------------------------------------------------------------
module prcb_datapath #(
    parameter int RECORD_DEPTH   = 16384,
    parameter int PRE_ROLL_DEPTH = 4096
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [prcb_pkg::CFG_AW-1:0]  cfg_addr,
    input  logic [prcb_pkg::CFG_DW-1:0]  cfg_wdata,
    input  logic [prcb_pkg::IN_W-1:0]    s_tdata,
    input  logic                         m_tready,
    output logic                         m_tvalid,
    output logic [prcb_pkg::OUT_W-1:0]   m_tdata,
    input  prcb_pkg::cmd_t               cmd,
    output prcb_pkg::status_t            status
);
    import prcb_pkg::*;

    localparam int RA_W = (RECORD_DEPTH > 1) ? $clog2(RECORD_DEPTH) : 1;
    localparam int PA_W = (PRE_ROLL_DEPTH > 1) ? $clog2(PRE_ROLL_DEPTH) : 1;
    localparam int RX_W = (RA_W > CNT_W) ? RA_W : CNT_W;
    localparam int PX_W = (PA_W > RING_W) ? PA_W : RING_W;

    localparam logic [CNT_W-1:0] REC_LIM =
        (RECORD_DEPTH >= (1 << CNT_W) - 1) ? {CNT_W{1'b1}} : CNT_W'(RECORD_DEPTH);
    localparam logic [RING_W-1:0] RING_LIM =
        (PRE_ROLL_DEPTH >= (1 << RING_W) - 1) ? {RING_W{1'b1}} : RING_W'(PRE_ROLL_DEPTH);

    // config
    logic [CNT_W-1:0]  rec_cap_cfg_reg;
    logic [RING_W-1:0] ring_cap_cfg_reg;
    logic [RATE_W-1:0] rate_reg;

    // latched item
    mode_t             mode_reg;
    logic [SMP_W-1:0]  sample_reg;
    logic [RIDX_W-1:0] ridx_reg;

    // buffer state
    logic [CNT_W-1:0]  rec_cnt_reg, rec_cnt_next;
    logic [RING_W-1:0] ring_cnt_reg, ring_cnt_next;
    logic [RING_W-1:0] wpos_reg, wpos_next;
    bstate_t           bstate_reg, bstate_next;
    logic              ovf_reg, ovf_next;
    logic              ok_reg, ok_next;
    logic [RING_W-1:0] copy_idx_reg, copy_idx_next;
    logic [RING_W-1:0] copy_left_reg, copy_left_next;

    // stores
    logic [SMP_W-1:0]  rec_mem [RECORD_DEPTH];
    logic [SMP_W-1:0]  ring_mem [PRE_ROLL_DEPTH];
    logic [SMP_W-1:0]  rec_q_reg, ring_q_reg;
    logic              rec_we, rec_re, ring_we, ring_re;
    logic [SMP_W-1:0]  rec_wdata;
    logic [RX_W-1:0]   rec_wa_x, rec_ra_x;
    logic [PX_W-1:0]   ring_wa_x, ring_ra_x;

    // result register
    logic              m_tvalid_reg;
    logic [OUT_W-1:0]  m_tdata_reg;

    // derived
    logic [CNT_W-1:0]  rec_cap;
    logic [RING_W-1:0] ring_cap, rc_clamp, wp_cur, wp_inc, wp_wrap, cp_inc;
    logic              rec_full, read_ok;
    logic              div_busy;
    logic [DVD_W-1:0]  quotient;
    logic [DUR_W-1:0]  dur;
    logic [SMP_W-1:0]  rd_out;

    always_comb begin
        rec_cap  = (rec_cap_cfg_reg < REC_LIM) ? rec_cap_cfg_reg : REC_LIM;
        ring_cap = (ring_cap_cfg_reg < RING_LIM) ? ring_cap_cfg_reg : RING_LIM;
        rc_clamp = (ring_cnt_reg > ring_cap) ? ring_cap : ring_cnt_reg;
        wp_cur   = (wpos_reg >= ring_cap) ? '0 : wpos_reg;
        wp_inc   = wp_cur + 1'b1;
        wp_wrap  = (wp_inc >= ring_cap) ? '0 : wp_inc;
        cp_inc   = copy_idx_reg + 1'b1;
        rec_full = rec_cnt_reg >= rec_cap;
        read_ok  = ({1'b0, ridx_reg} < rec_cnt_reg) && (32'(ridx_reg) < RECORD_DEPTH);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rec_cap_cfg_reg  <= REC_CAP_RST;
            ring_cap_cfg_reg <= RING_CAP_RST;
            rate_reg         <= RATE_RST;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_addr))
                CFG_REC_CAP:  rec_cap_cfg_reg  <= cfg_wdata[CNT_W-1:0];
                CFG_RING_CAP: ring_cap_cfg_reg <= cfg_wdata[RING_W-1:0];
                CFG_RATE:     rate_reg         <= cfg_wdata[RATE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg   <= mode_t'(s_tdata[2:0]);
            sample_reg <= s_tdata[18:3];
            ridx_reg   <= s_tdata[32:19];
        end
    end

    always_comb begin
        rec_cnt_next   = rec_cnt_reg;
        ring_cnt_next  = ring_cnt_reg;
        wpos_next      = wpos_reg;
        bstate_next    = bstate_reg;
        ovf_next       = ovf_reg;
        ok_next        = ok_reg;
        copy_idx_next  = copy_idx_reg;
        copy_left_next = copy_left_reg;
        rec_we         = 1'b0;
        rec_re         = 1'b0;
        ring_we        = 1'b0;
        ring_re        = 1'b0;
        rec_wdata      = sample_reg;

        if (cmd.exec) begin
            case (mode_reg)
                MODE_PUSH: begin
                    if (bstate_reg == BS_RECORDING) begin
                        if (rec_full) begin
                            ovf_next = 1'b1;
                            ok_next  = 1'b0;
                        end else begin
                            rec_we       = 1'b1;
                            rec_cnt_next = rec_cnt_reg + 1'b1;
                            ok_next      = 1'b1;
                        end
                    end else begin
                        ok_next = 1'b1;
                        if (ring_cap != '0) begin
                            ring_we       = 1'b1;
                            wpos_next     = wp_wrap;
                            ring_cnt_next = (rc_clamp < ring_cap) ? rc_clamp + 1'b1 : rc_clamp;
                        end
                    end
                end
                MODE_START: begin
                    if (rec_cap != '0) begin
                        rec_cnt_next   = '0;
                        ovf_next       = 1'b0;
                        bstate_next    = BS_RECORDING;
                        ok_next        = 1'b1;
                        // full ring starts at the oldest entry, partial ring at zero
                        copy_idx_next  = (rc_clamp == ring_cap) ? wp_cur : '0;
                        copy_left_next = rc_clamp;
                    end else begin
                        ok_next = 1'b0;
                    end
                end
                MODE_STOP: begin
                    if (bstate_reg == BS_RECORDING) begin
                        bstate_next   = BS_READY;
                        ring_cnt_next = '0;
                        wpos_next     = '0;
                        ok_next       = 1'b1;
                    end else begin
                        ok_next = 1'b0;
                    end
                end
                MODE_RESET: begin
                    rec_cnt_next  = '0;
                    ring_cnt_next = '0;
                    wpos_next     = '0;
                    bstate_next   = BS_IDLE;
                    ovf_next      = 1'b0;
                    ok_next       = 1'b1;
                end
                MODE_READ: begin
                    rec_re  = 1'b1;
                    ok_next = read_ok;
                end
                default: ok_next = 1'b0;
            endcase
        end

        if (cmd.copy_rd) begin
            ring_re        = 1'b1;
            copy_idx_next  = (cp_inc >= ring_cap) ? '0 : cp_inc;
            copy_left_next = copy_left_reg - 1'b1;
        end

        if (cmd.copy_wr) begin
            rec_wdata = ring_q_reg;
            if (rec_full) begin
                ovf_next = 1'b1;
            end else begin
                rec_we       = 1'b1;
                rec_cnt_next = rec_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rec_cnt_reg  <= '0;
            ring_cnt_reg <= '0;
            wpos_reg     <= '0;
            bstate_reg   <= BS_IDLE;
            ovf_reg      <= 1'b0;
        end else begin
            rec_cnt_reg  <= rec_cnt_next;
            ring_cnt_reg <= ring_cnt_next;
            wpos_reg     <= wpos_next;
            bstate_reg   <= bstate_next;
            ovf_reg      <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        ok_reg        <= ok_next;
        copy_idx_reg  <= copy_idx_next;
        copy_left_reg <= copy_left_next;
    end

    assign rec_wa_x  = RX_W'(rec_cnt_reg);
    assign rec_ra_x  = RX_W'(ridx_reg);
    assign ring_wa_x = PX_W'(wp_cur);
    assign ring_ra_x = PX_W'(copy_idx_reg);

    always_ff @(posedge aclk) begin
        if (rec_we) begin
            rec_mem[rec_wa_x[RA_W-1:0]] <= rec_wdata;
        end
        if (rec_re) begin
            rec_q_reg <= rec_mem[rec_ra_x[RA_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring_mem[ring_wa_x[PA_W-1:0]] <= sample_reg;
        end
        if (ring_re) begin
            ring_q_reg <= ring_mem[ring_ra_x[PA_W-1:0]];
        end
    end

    prcb_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (DVD_W'(rec_cnt_reg) * DVD_W'(MS_PER_S)),
        .divisor  (rate_reg),
        .busy     (div_busy),
        .quotient (quotient)
    );

    always_comb begin
        dur    = (rate_reg == '0) ? '0 : quotient[DUR_W-1:0];
        rd_out = (mode_reg == MODE_READ && ok_reg) ? rec_q_reg : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= {5'b0, rd_out, dur, {rec_cnt_reg[BYTE_W-2:0], 1'b0},
                            rec_cnt_reg, ovf_reg, bstate_reg, ok_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        status.mode      = mode_reg;
        status.start_ok  = rec_cap != '0;
        status.copy_none = rc_clamp == '0;
        status.copy_last = copy_left_reg == '0;
        status.div_busy  = div_busy;
        status.out_free  = !m_tvalid_reg || m_tready;
    end

endmodule

>>> hdl/prcb_ctrl.sv
// ----------------------------------------------------------------------------
// prcb_ctrl
// Sequencer: accept, execute, ring copy, duration divide, result hand-off.
// ----------------------------------------------------------------------------
module prcb_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  prcb_pkg::status_t status,
    output prcb_pkg::cmd_t    cmd
);
    import prcb_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            CS_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = CS_EXEC;
                end
            end
            CS_EXEC: begin
                cmd.exec = 1'b1;
                if (status.mode == MODE_START && status.start_ok && !status.copy_none) begin
                    state_next = CS_COPY_RD;
                end else begin
                    state_next = CS_DIV_START;
                end
            end
            CS_COPY_RD: begin
                cmd.copy_rd = 1'b1;
                state_next  = CS_COPY_WR;
            end
            CS_COPY_WR: begin
                cmd.copy_wr = 1'b1;
                state_next  = status.copy_last ? CS_DIV_START : CS_COPY_RD;
            end
            CS_DIV_START: begin
                cmd.div_start = 1'b1;
                state_next    = CS_DIV;
            end
            CS_DIV: begin
                if (!status.div_busy) begin
                    state_next = CS_DONE;
                end
            end
            CS_DONE: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = CS_IDLE;
                end
            end
            default: state_next = CS_IDLE;
        endcase
    end

endmodule

>>> hdl/pre_roll_capture_buffer_core.sv
// ----------------------------------------------------------------------------
// pre_roll_capture_buffer_core
// Audio capture buffer with pre-roll ring, record store and status report.
//
//   channel   dir  fields (low bit up)
//   s_*       in   mode[2:0] sample[18:3] rd_index[32:19]
//   m_*       out  ok[0] buffer_state[2:1] overflowed[3] recorded_count[18:4]
//                  byte_count[34:19] duration_ms[58:35] read_sample[74:59]
//   cfg_*     in   index 0 record_capacity, 1 pre_roll_capacity, 2 sample_rate_hz
//
// One item at a time: every mode, undefined ones included, goes through the
// duration divider before its result is handed off.
// A start first copies each buffered pre-roll sample (one ring read, one store write).
// Synchronous active-low reset clears control state; stores are not cleared.
// A result waiting on m_tready does not block the next accept; only its own
// hand-off into the output register waits.
// ----------------------------------------------------------------------------
module pre_roll_capture_buffer_core #(
    parameter int RECORD_DEPTH   = 16384,
    parameter int PRE_ROLL_DEPTH = 4096
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [prcb_pkg::CFG_AW-1:0] cfg_addr,
    input  logic [prcb_pkg::CFG_DW-1:0] cfg_wdata,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // mode[2:0], sample[18:3], rd_index[32:19], zero fill
    input  logic [prcb_pkg::IN_W-1:0]   s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // ok, buffer_state, overflowed, recorded_count, byte_count,
    // duration_ms, read_sample, zero fill
    output logic [prcb_pkg::OUT_W-1:0]  m_tdata
);
    import prcb_pkg::*;

    cmd_t    cmd;
    status_t status;

    prcb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    prcb_datapath #(
        .RECORD_DEPTH   (RECORD_DEPTH),
        .PRE_ROLL_DEPTH (PRE_ROLL_DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

>>> hdl/prcb_checker.sv
// ----------------------------------------------------------------------------
// prcb_checker
// Port-level checks for the pre-roll capture buffer, bound to the top level.
// ----------------------------------------------------------------------------
module prcb_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [prcb_pkg::OUT_W-1:0]  m_tdata
);
    import prcb_pkg::*;

    // held result must not change
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // output register is empty right after reset
    a_rst_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // one item in flight: no second accept right behind the first
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    // byte count is twice the recorded count, state code in range
    a_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[34:20] == m_tdata[18:4]) && !m_tdata[19]
                     && (m_tdata[2:1] != 2'd3))
        else $error("inconsistent result fields");

endmodule

bind pre_roll_capture_buffer_core prcb_checker u_prcb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the pre-roll capture buffer. A queue of commands
// (directed, then random capture takes and noise over several register
// settings) feeds a stream driver; a shadow model of ring, record store and
// status predicts every result, and the monitor checks each field in order.
// ----------------------------------------------------------------------------
module testbench;
    import prcb_pkg::*;

    localparam int REC_DEPTH  = 16384;
    localparam int RING_DEPTH = 4096;

    typedef struct {
        logic [MODE_W-1:0] mode;
        logic [SMP_W-1:0]  sample;
        logic [RIDX_W-1:0] ridx;
    } capture_cmd_t;

    typedef struct packed {
        logic              ok;
        bstate_t           state;
        logic              overflow;
        logic [CNT_W-1:0]  count;
        logic [BYTE_W-1:0] bytes;
        logic [DUR_W-1:0]  dur_ms;
        logic [SMP_W-1:0]  pcm;
    } capture_status_t;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              cfg_we;
    logic [CFG_AW-1:0] cfg_addr;
    logic [CFG_DW-1:0] cfg_wdata;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;

    // shadow of the block
    logic [SMP_W-1:0] rec_shadow [REC_DEPTH];
    logic [SMP_W-1:0] ring_shadow [RING_DEPTH];
    int unsigned      rec_cnt, ring_cnt, ring_wp;
    bstate_t          buf_st;
    bit               ovf;
    int unsigned      rec_cap_r, ring_cap_r, rate_r;

    capture_cmd_t    cmd_q[$];
    capture_status_t status_q[$];
    capture_cmd_t    next_cmd;
    capture_cmd_t    seen_cmd;
    capture_status_t got, want;

    int unsigned queued_no, accepted_no, sent_no, results_seen, errors;
    int unsigned send_idle, recv_idle;
    logic        in_taken, out_taken;

    pre_roll_capture_buffer_core #(
        .RECORD_DEPTH   (REC_DEPTH),
        .PRE_ROLL_DEPTH (RING_DEPTH)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #1 aclk = ~aclk;

    function automatic int unsigned rec_limit();
        return (rec_cap_r < REC_DEPTH) ? rec_cap_r : REC_DEPTH;
    endfunction

    function automatic int unsigned ring_limit();
        return (ring_cap_r < RING_DEPTH) ? ring_cap_r : RING_DEPTH;
    endfunction

    function automatic bit store_sample(logic [SMP_W-1:0] s);
        if (rec_cnt >= rec_limit()) begin
            ovf = 1'b1;
            return 1'b0;
        end
        rec_shadow[rec_cnt] = s;
        rec_cnt++;
        return 1'b1;
    endfunction

    function automatic capture_status_t capture_step(capture_cmd_t c);
        capture_status_t r;
        int unsigned cap, w, n, first, idx, i;
        longint unsigned prod;
        r = '0;
        case (c.mode)
            MODE_PUSH: begin
                if (buf_st == BS_RECORDING) begin
                    r.ok = store_sample(c.sample);
                end else begin
                    cap = ring_limit();
                    if (cap != 0) begin
                        w = (ring_wp >= cap) ? 0 : ring_wp;
                        ring_shadow[w] = c.sample;
                        w++;
                        if (w >= cap) w = 0;
                        ring_wp = w;
                        if (ring_cnt > cap) ring_cnt = cap;
                        if (ring_cnt < cap) ring_cnt++;
                    end
                    r.ok = 1'b1;
                end
            end
            MODE_START: begin
                if (rec_limit() != 0) begin
                    rec_cnt = 0;
                    ovf = 1'b0;
                    // ring goes out oldest first; a full ring starts at the write pointer
                    cap = ring_limit();
                    n = (ring_cnt < cap) ? ring_cnt : cap;
                    first = 0;
                    if (n != 0 && n == cap) first = (ring_wp < cap) ? ring_wp : 0;
                    for (i = 0; i < n; i++) begin
                        idx = first + i;
                        if (idx >= cap) idx -= cap;
                        void'(store_sample(ring_shadow[idx]));
                    end
                    buf_st = BS_RECORDING;
                    r.ok = 1'b1;
                end
            end
            MODE_STOP: begin
                if (buf_st == BS_RECORDING) begin
                    buf_st = BS_READY;
                    ring_cnt = 0;
                    ring_wp = 0;
                    r.ok = 1'b1;
                end
            end
            MODE_RESET: begin
                rec_cnt = 0;
                ring_cnt = 0;
                ring_wp = 0;
                buf_st = BS_IDLE;
                ovf = 1'b0;
                r.ok = 1'b1;
            end
            MODE_READ: begin
                if (c.ridx < rec_cnt) begin
                    r.pcm = rec_shadow[c.ridx];
                    r.ok = 1'b1;
                end
            end
            default: ;
        endcase
        r.state = buf_st;
        r.overflow = ovf;
        r.count = CNT_W'(rec_cnt);
        r.bytes = BYTE_W'(rec_cnt * 2);
        if (rate_r != 0) begin
            prod = 64'(rec_cnt) * 64'(MS_PER_S);
            r.dur_ms = DUR_W'(prod / 64'(rate_r));
        end
        return r;
    endfunction

    function automatic int unsigned pick_idle(int unsigned n);
        // every third run of 40 items goes without idling
        return ((n / 40) % 3 == 0) ? 0 : $urandom_range(0, 16);
    endfunction

    task automatic flag_mismatch(string what, logic [31:0] got_v, logic [31:0] exp_v);
        $display("result %0d: %s is %0h, expected %0h", results_seen, what, got_v, exp_v);
        errors++;
    endtask

    // input side
    always @(negedge aclk) begin
        if (aresetn) begin
            if (in_taken || !s_tvalid) begin
                if (send_idle > 0) begin
                    send_idle--;
                    s_tvalid <= 1'b0;
                end else if (cmd_q.size() != 0) begin
                    next_cmd = cmd_q.pop_front();
                    s_tdata <= IN_W'({next_cmd.ridx, next_cmd.sample, next_cmd.mode});
                    s_tvalid <= 1'b1;
                    send_idle = pick_idle(sent_no);
                    sent_no++;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result side back-pressure
    always @(negedge aclk) begin
        if (aresetn) begin
            if (out_taken) recv_idle = pick_idle(results_seen);
            if (recv_idle > 0) begin
                recv_idle--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            in_taken <= 1'b0;
            out_taken <= 1'b0;
        end else begin
            in_taken <= s_tvalid && s_tready;
            out_taken <= m_tvalid && m_tready;
            // check before predicting so a same-edge accept never feeds this compare
            if (m_tvalid && m_tready) begin
                if (status_q.size() == 0) begin
                    flag_mismatch("unexpected item, low word", m_tdata[31:0], '0);
                end else begin
                    want = status_q.pop_front();
                    got.ok = m_tdata[0];
                    got.state = bstate_t'(m_tdata[2:1]);
                    got.overflow = m_tdata[3];
                    got.count = m_tdata[18:4];
                    got.bytes = m_tdata[34:19];
                    got.dur_ms = m_tdata[58:35];
                    got.pcm = m_tdata[74:59];
                    if (got.ok !== want.ok) flag_mismatch("ok", got.ok, want.ok);
                    if (got.state !== want.state)
                        flag_mismatch("buffer_state", got.state, want.state);
                    if (got.overflow !== want.overflow)
                        flag_mismatch("overflowed", got.overflow, want.overflow);
                    if (got.count !== want.count)
                        flag_mismatch("recorded_count", got.count, want.count);
                    if (got.bytes !== want.bytes)
                        flag_mismatch("byte_count", got.bytes, want.bytes);
                    if (got.dur_ms !== want.dur_ms)
                        flag_mismatch("duration_ms", got.dur_ms, want.dur_ms);
                    if (got.pcm !== want.pcm)
                        flag_mismatch("read_sample", got.pcm, want.pcm);
                end
                results_seen++;
            end
            if (s_tvalid && s_tready) begin
                seen_cmd.mode = s_tdata[MODE_W-1:0];
                seen_cmd.sample = s_tdata[MODE_W +: SMP_W];
                seen_cmd.ridx = s_tdata[MODE_W+SMP_W +: RIDX_W];
                status_q.push_back(capture_step(seen_cmd));
                accepted_no++;
            end
        end
    end

    task automatic queue_cmd(logic [MODE_W-1:0] m, logic [SMP_W-1:0] s, logic [RIDX_W-1:0] ix);
        capture_cmd_t c;
        c.mode = m;
        c.sample = s;
        c.ridx = ix;
        cmd_q.push_back(c);
        queued_no++;
    endtask

    task automatic wait_drained();
        while (accepted_no != queued_no || status_q.size() != 0) @(negedge aclk);
        repeat (2) @(negedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, int unsigned v);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= CFG_DW'(v);
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_REC_CAP:  rec_cap_r = CNT_W'(v);
            CFG_RING_CAP: ring_cap_r = RING_W'(v);
            CFG_RATE:     rate_r = RATE_W'(v);
            default: ;
        endcase
    endtask

    function automatic logic [SMP_W-1:0] rand_pcm();
        case ($urandom_range(0, 11))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return SMP_W'($urandom);
        endcase
    endfunction

    function automatic logic [RIDX_W-1:0] rand_index(int unsigned lim);
        if ($urandom_range(0, 5) == 0) return RIDX_W'($urandom);
        return RIDX_W'($urandom_range(0, ((lim > 48) ? 48 : lim) + 2));
    endfunction

    task automatic set_phase(int unsigned rec, int unsigned ring, int unsigned rate);
        // growing the ring over old pushes would expose slots never written
        if (ring > ring_cap_r) begin
            queue_cmd(MODE_RESET, rand_pcm(), rand_index(0));
            wait_drained();
        end
        write_reg(CFG_REC_CAP, rec);
        write_reg(CFG_RING_CAP, ring);
        write_reg(CFG_RATE, rate);
    endtask

    // pre-roll pushes, start, recording, mostly a stop, then reads, sometimes a reset
    task automatic queue_take(int unsigned rlim, int unsigned plim);
        int unsigned n_pre, n_rec;
        n_pre = $urandom_range(0, (2 * plim + 2 > 40) ? 40 : 2 * plim + 2);
        n_rec = $urandom_range(0, (rlim + 4 > 40) ? 40 : rlim + 4);
        repeat (n_pre) queue_cmd(MODE_PUSH, rand_pcm(), rand_index(rlim));
        queue_cmd(MODE_START, rand_pcm(), rand_index(rlim));
        repeat (n_rec) queue_cmd(MODE_PUSH, rand_pcm(), rand_index(rlim));
        if ($urandom_range(0, 4) != 0) queue_cmd(MODE_STOP, rand_pcm(), rand_index(rlim));
        repeat ($urandom_range(1, 6)) queue_cmd(MODE_READ, rand_pcm(), rand_index(rlim));
        if ($urandom_range(0, 3) == 0) queue_cmd(MODE_RESET, rand_pcm(), rand_index(rlim));
    endtask

    initial begin
        int unsigned p, stop_at;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = CFG_REC_CAP;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        rec_cnt = 0;
        ring_cnt = 0;
        ring_wp = 0;
        buf_st = BS_IDLE;
        ovf = 1'b0;
        rec_cap_r = REC_CAP_RST;
        ring_cap_r = RING_CAP_RST;
        rate_r = RATE_RST;
        queued_no = 0;
        accepted_no = 0;
        sent_no = 0;
        results_seen = 0;
        errors = 0;
        send_idle = 0;
        recv_idle = 0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: empty reads, bad stop, undefined modes, extremes, restart
        queue_cmd(MODE_READ, 16'h0000, '0);
        queue_cmd(MODE_STOP, 16'h0000, '0);
        for (p = 1; p <= 3; p++) queue_cmd(MODE_W'(int'(MODE_READ) + p), 16'hFFFF, '1);
        queue_cmd(MODE_PUSH, 16'h8000, '0);
        queue_cmd(MODE_PUSH, 16'h7FFF, '1);
        queue_cmd(MODE_PUSH, 16'h0000, '0);
        queue_cmd(MODE_PUSH, 16'hFFFF, '1);
        queue_cmd(MODE_START, 16'h0000, '0);
        queue_cmd(MODE_PUSH, 16'h1234, '0);
        queue_cmd(MODE_READ, 16'h0000, 14'd0);
        queue_cmd(MODE_READ, 16'h0000, 14'd4);
        queue_cmd(MODE_READ, 16'h0000, 14'd5);
        queue_cmd(MODE_READ, 16'hFFFF, '1);
        queue_cmd(MODE_START, 16'h0000, '0);
        queue_cmd(MODE_STOP, 16'h0000, '0);
        queue_cmd(MODE_STOP, 16'h0000, '0);
        queue_cmd(MODE_READ, 16'h0000, 14'd3);
        queue_cmd(MODE_START, 16'h0000, '0);
        queue_cmd(MODE_PUSH, 16'h5A5A, '0);
        queue_cmd(MODE_RESET, 16'h0000, '0);
        queue_cmd(MODE_READ, 16'h0000, 14'd0);
        queue_cmd(MODE_PUSH, 16'hA5A5, '0);
        wait_drained();

        for (p = 0; p < 10; p++) begin
            case (p)
                0: set_phase(20, 8, 1000);
                1: set_phase(5, 16, 0);
                2: set_phase(0, 0, 192000);
                3: set_phase(16384, 4096, 16000);
                4: set_phase(1, 1, 1);
                5: set_phase(60, 12, 44100);
                6: set_phase(3, 2, 7);
                default: set_phase($urandom_range(0, 48), $urandom_range(0, 24),
                                   $urandom_range(0, 192000));
            endcase
            stop_at = queued_no + 78;
            while (queued_no < stop_at) begin
                if ($urandom_range(0, 4) != 0) begin
                    queue_take(rec_limit(), ring_limit());
                end else begin
                    repeat ($urandom_range(1, 5))
                        queue_cmd(MODE_W'($urandom_range(0, (1 << MODE_W) - 1)), rand_pcm(),
                                  rand_index(rec_limit()));
                end
            end
            // sender holds off here until every result is back
            wait_drained();
        end

        repeat (40) @(posedge aclk);
        if (errors == 0 && status_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule
